// File: sv/ffc_pkg.sv
// Package for the float/fixed converter: field widths, codes and shared types.
// No dependencies.
`default_nettype none
package ffc_pkg;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int CFG_W = 6;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_WIDE = 2'd2;
    localparam logic OP_F2X = 1'b0;
    localparam logic OP_X2F = 1'b1;
    localparam logic [1:0] REG_FRAC = 2'd0;
    localparam logic [1:0] REG_INT = 2'd1;
    localparam logic [1:0] REG_SIGNED = 2'd2;

    // Item state after the first stage.
    typedef struct packed {
        logic        op;
        logic        wide;
        logic        neg;
        logic        nan;
        logic        huge;
        logic        zero;
        logic [63:0] ip;
        logic [63:0] rnd;
        logic        frac;
        logic [63:0] lim;
        logic [5:0]  fr;
        logic [31:0] u;
    } s1_t;
endpackage
`default_nettype wire

// File: sv/float_fixed_converter_unit.sv
// Top level of the float/fixed converter: three-stage pipeline with stall.
// Depends on ffc_pkg.
//
// Channel | Dir | tdata fields (low bit up)                  | tuser
// s_      | in  | operation[0], float_bits[32:1], fixed[64:33] | -
// m_      | out | result_bits[31:0], status[33:32]            | -
//
// One transaction per cycle while the output is not stalled; a result passes through
// the stage 1, stage 2 and stage 3 registers before it is offered.
// Stage 1 decodes and shifts, stage 2 checks range and finds the leading one,
// stage 3 rounds and packs. Reset clears the valid bits and loads the format registers with defaults.
// A stall holds every full stage whose successor cannot move on; nothing is lost.
`default_nettype none
module float_fixed_converter_unit #(
    parameter int WORD_WIDTH = ffc_pkg::WORD_WIDTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // operation, float_bits, fixed_word
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // result_bits, status
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [5:0]  cfg_data
);
    logic [5:0] frac_reg, int_reg;
    logic       sgn_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= '0; int_reg <= 6'd32; sgn_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                ffc_pkg::REG_FRAC:   frac_reg <= cfg_data;
                ffc_pkg::REG_INT:    int_reg <= cfg_data;
                ffc_pkg::REG_SIGNED: sgn_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v3_reg;

    // Stage 1: decode and align.
    ffc_pkg::s1_t s1_next, s1_reg;
    always_comb begin
        logic        op, sg;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [6:0]  w;
        logic [63:0] posmax, negmag, mag, m2;
        logic signed [9:0] sh;
        logic [5:0] k;
        logic [31:0] fw;
        op = s_tdata[0];
        fw = s_tdata[64:33];
        sg = s_tdata[32];
        ex = s_tdata[31:24];
        man = s_tdata[23:1];
        k = '0;
        m2 = '0;
        w = {1'b0, int_reg} + {1'b0, frac_reg};
        posmax = '0; negmag = '0;
        if (w != 0) begin
            if (sgn_reg) begin
                negmag = 64'd1 << (w - 7'd1);
                posmax = negmag - 64'd1;
            end else begin
                posmax = (64'd1 << w) - 64'd1;
            end
        end
        s1_next = '0;
        s1_next.op = op;
        s1_next.fr = frac_reg;
        s1_next.wide = (w > 7'(WORD_WIDTH)) || (w > 7'd32);
        mag = {40'd0, (ex != 0), man};
        sh = $signed({2'b0, (ex != 0) ? ex : 8'd1}) - 10'sd150
             + $signed({4'b0, frac_reg});
        if (op == ffc_pkg::OP_F2X) begin
            s1_next.neg = sg;
            s1_next.lim = sg ? negmag : posmax;
            s1_next.nan = (ex == 8'hFF) && (man != 0);
            s1_next.huge = (ex == 8'hFF);
            s1_next.zero = (ex != 8'hFF) && (mag == 0);
            if (sh >= 0) begin
                if (sh > 10'sd39) s1_next.huge = 1'b1;
                else begin
                    s1_next.ip = mag << sh[5:0];
                    s1_next.rnd = s1_next.ip;
                end
            end else if (-sh >= 10'sd25) begin
                s1_next.frac = 1'b1;
            end else begin
                k = 6'(-sh);
                s1_next.ip = mag >> k;
                m2 = mag & ((64'd1 << k) - 64'd1);
                s1_next.frac = (m2 != 0);
                s1_next.rnd = (mag + (64'd1 << (k - 6'd1))) >> k;
            end
        end else begin
            s1_next.neg = sgn_reg && fw[31];
            s1_next.u = s1_next.neg ? (32'd0 - fw) : fw;
            s1_next.lim = s1_next.neg ? negmag : posmax;
        end
    end

    // Stage 2: range check, leading one.
    logic [31:0] res2_next, res2_reg;
    logic [1:0]  st2_next, st2_reg;
    logic [4:0]  p2_next, p2_reg;
    ffc_pkg::s1_t s2_reg;
    always_comb begin
        logic [63:0] r;
        r = s1_reg.rnd;
        res2_next = '0; st2_next = ffc_pkg::ST_OK; p2_next = '0;
        if (s1_reg.wide) st2_next = ffc_pkg::ST_WIDE;
        else if (s1_reg.op == ffc_pkg::OP_F2X) begin
            if (s1_reg.nan) st2_next = ffc_pkg::ST_RANGE;
            else if (!s1_reg.zero) begin
                if (s1_reg.huge || s1_reg.ip > s1_reg.lim
                    || (s1_reg.ip == s1_reg.lim && s1_reg.frac)) begin
                    st2_next = ffc_pkg::ST_RANGE; r = s1_reg.lim;
                end
                res2_next = s1_reg.neg ? 32'd0 - r[31:0] : r[31:0];
            end
        end else begin
            st2_next = ({32'd0, s1_reg.u} > s1_reg.lim) ? ffc_pkg::ST_RANGE
                                                         : ffc_pkg::ST_OK;
            for (int i = 0; i < 32; i++)
                if (s1_reg.u[i]) p2_next = 5'(i);
        end
    end

    // Stage 3: round to single and pack; float-to-fixed results pass through.
    logic [31:0] res3_next, res3_reg;
    logic [1:0]  st3_reg;
    always_comb begin
        logic [31:0] u, keep, rem, half;
        logic [5:0]  p, s;
        logic [7:0]  ex;
        u = s2_reg.u;
        p = {1'b0, p2_reg};
        res3_next = res2_reg;
        keep = '0;
        rem = '0;
        half = '0;
        s = '0;
        ex = '0;
        if (s2_reg.op == ffc_pkg::OP_X2F && !s2_reg.wide) begin
            if (u == 0) res3_next = '0;
            else begin
                if (p <= 6'd23) keep = u << (6'd23 - p);
                else begin
                    s = p - 6'd23;
                    rem = u & ((32'd1 << s) - 32'd1);
                    half = 32'd1 << (s - 6'd1);
                    keep = u >> s;
                    if (rem > half || (rem == half && keep[0])) keep = keep + 32'd1;
                    if (keep == 32'h0100_0000) begin
                        keep = keep >> 1; p = p + 6'd1;
                    end
                end
                ex = 8'(p) + 8'd127 - 8'(s2_reg.fr);
                res3_next = {s2_reg.neg, ex, keep[22:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
        if (en1) s1_reg <= s1_next;
        if (en2) begin
            s2_reg <= s1_reg; res2_reg <= res2_next;
            st2_reg <= st2_next; p2_reg <= p2_next;
        end
        if (en3) begin
            res3_reg <= res3_next; st3_reg <= st2_reg;
        end
    end

    assign m_tdata = {6'd0, st3_reg, res3_reg};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
    a_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st3_reg != 2'd3) else $error("status");
    a_wide: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st3_reg == ffc_pkg::ST_WIDE |-> res3_reg == 0) else $error("wide");
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for float_fixed_converter_unit: predicts each conversion
// in both directions and compares it with the output stream. Depends on ffc_pkg and the RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] result_bits;
        logic [1:0]  status;
    } conv_result_t;

    class conv_scoreboard;
        logic [5:0] frac_bits;
        logic [5:0] int_bits;
        logic       signed_mode;
        conv_result_t pending[$];
        int errors;
        int checked;

        function new();
            frac_bits = 6'd0;
            int_bits = 6'd32;
            signed_mode = 1'b1;
            errors = 0;
            checked = 0;
        endfunction

        function conv_result_t float_to_fixed(logic [31:0] fb, logic [63:0] posmax,
                                              logic [63:0] negmag);
            conv_result_t r;
            logic sgn;
            logic [7:0] ex;
            logic [22:0] man;
            logic [63:0] mag, ip, rnd, lim;
            logic frac, huge;
            int sh, k;
            sgn = fb[31];
            ex = fb[30:23];
            man = fb[22:0];
            ip = 0;
            rnd = 0;
            frac = 0;
            huge = 0;
            if (ex == 8'hFF && man != 0) begin
                r.result_bits = 0;
                r.status = ffc_pkg::ST_RANGE;
                return r;
            end
            if (ex == 8'hFF) begin
                huge = 1;
            end else begin
                mag = (ex != 0) ? {40'd0, 1'b1, man} : {41'd0, man};
                if (mag == 0) begin
                    r.result_bits = 0;
                    r.status = ffc_pkg::ST_OK;
                    return r;
                end
                sh = ((ex != 0) ? int'(ex) : 1) - 150 + int'(frac_bits);
                if (sh >= 0) begin
                    if (sh > 39) huge = 1;
                    else begin
                        ip = mag << sh;
                        rnd = ip;
                    end
                end else begin
                    k = -sh;
                    if (k >= 25) begin
                        frac = 1;
                    end else begin
                        ip = mag >> k;
                        frac = (mag & ((64'd1 << k) - 1)) != 0;
                        rnd = (mag + (64'd1 << (k - 1))) >> k;
                    end
                end
            end
            lim = sgn ? negmag : posmax;
            if (huge || ip > lim || (ip == lim && frac)) begin
                r.status = ffc_pkg::ST_RANGE;
                rnd = lim;
            end else begin
                r.status = ffc_pkg::ST_OK;
            end
            r.result_bits = sgn ? 32'd0 - rnd[31:0] : rnd[31:0];
            return r;
        endfunction

        function logic [31:0] int_to_single(logic neg, logic [31:0] u);
            int p, s;
            logic [31:0] keep, rem, half;
            logic [7:0] ex;
            if (u == 0) return 32'd0;
            p = 31;
            while (u[p] == 1'b0) p--;
            if (p <= 23) begin
                keep = u << (23 - p);
            end else begin
                s = p - 23;
                rem = u & ((32'd1 << s) - 1);
                half = 32'd1 << (s - 1);
                keep = u >> s;
                if (rem > half || (rem == half && keep[0])) keep++;
                if (keep == 32'h0100_0000) begin
                    keep = keep >> 1;
                    p++;
                end
            end
            ex = 8'(p + 127 - int'(frac_bits));
            return {neg, ex, keep[22:0]};
        endfunction

        function conv_result_t convert(logic op, logic [31:0] fb, logic [31:0] fw);
            conv_result_t r;
            int w;
            logic [63:0] posmax, negmag;
            logic neg;
            logic [31:0] u;
            w = int'(int_bits) + int'(frac_bits);
            posmax = 0;
            negmag = 0;
            if (w > 32) begin
                r.result_bits = 0;
                r.status = ffc_pkg::ST_WIDE;
                return r;
            end
            if (w > 0) begin
                if (signed_mode) begin
                    negmag = 64'd1 << (w - 1);
                    posmax = negmag - 1;
                end else begin
                    posmax = (64'd1 << w) - 1;
                end
            end
            if (op == ffc_pkg::OP_F2X) return float_to_fixed(fb, posmax, negmag);
            neg = signed_mode && fw[31];
            u = neg ? 32'd0 - fw : fw;
            r.status = ({32'd0, u} > (neg ? negmag : posmax)) ? ffc_pkg::ST_RANGE
                                                              : ffc_pkg::ST_OK;
            r.result_bits = int_to_single(neg, u);
            return r;
        endfunction

        function void set_register(logic [1:0] idx, logic [5:0] val);
            case (idx)
                ffc_pkg::REG_FRAC: frac_bits = val;
                ffc_pkg::REG_INT: int_bits = val;
                ffc_pkg::REG_SIGNED: signed_mode = val[0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [71:0] data);
            pending.push_back(convert(data[0], data[32:1], data[64:33]));
        endfunction

        function void check_result(logic [39:0] data);
            conv_result_t exp_r;
            checked++;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (data[31:0] !== exp_r.result_bits) begin
                $error("result_bits: expected %h, got %h", exp_r.result_bits, data[31:0]);
                errors++;
            end
            if (data[33:32] !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, data[33:32]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    conv_scoreboard sb;
    bit calm;
    int sent;

    float_fixed_converter_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("float_fixed_converter_unit regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result side: random stall bursts until the calm tail of the run.
    initial begin
        int n;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    task automatic send_item(logic op, logic [31:0] fb, logic [31:0] fw);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, fw, fb, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_format(logic [5:0] fr, logic [5:0] ib, logic sm);
        cfg_we <= 1'b1;
        cfg_index <= ffc_pkg::REG_FRAC;
        cfg_data <= fr;
        @(negedge aclk);
        cfg_index <= ffc_pkg::REG_INT;
        cfg_data <= ib;
        @(negedge aclk);
        cfg_index <= ffc_pkg::REG_SIGNED;
        cfg_data <= {5'd0, sm};
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_register(ffc_pkg::REG_FRAC, fr);
        sb.set_register(ffc_pkg::REG_INT, ib);
        sb.set_register(ffc_pkg::REG_SIGNED, {5'd0, sm});
    endtask

    // Floats biased toward special exponents, edge mantissas and exponents 100 to 165.
    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2: f[22:0] = ($urandom_range(0, 1) != 0) ? 23'h7FFFFF : 23'h0;
            3, 4, 5, 6: f[30:23] = 8'($urandom_range(100, 165));
            default: ;
        endcase
        return f;
    endfunction

    task automatic random_items(int n);
        for (int i = 0; i < n; i++) begin
            send_item(1'($urandom_range(0, 1)), rand_float(), $urandom);
        end
    endtask

    logic [31:0] directed_f[14] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000,
        32'hBF00_0000, 32'h3FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
        32'h0000_0001, 32'h7F7F_FFFF, 32'h4F00_0000, 32'hCF00_0000
    };
    logic [31:0] directed_x[9] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0100_0001, 32'h0100_0003, 32'h00FF_FFFF, 32'hFFFF_FFFE
    };

    initial begin
        logic [5:0] fr, ib;
        sb = new();
        calm = 1'b0;
        sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = ffc_pkg::REG_FRAC;
        cfg_data = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset format, a fractional format, a small unsigned one, then zero, too wide and all-fraction.
        foreach (directed_f[i]) send_item(ffc_pkg::OP_F2X, directed_f[i], $urandom);
        foreach (directed_x[i]) send_item(ffc_pkg::OP_X2F, $urandom, directed_x[i]);
        drain();
        write_format(6'd8, 6'd8, 1'b1);
        foreach (directed_f[i]) send_item(ffc_pkg::OP_F2X, directed_f[i], $urandom);
        drain();
        write_format(6'd4, 6'd4, 1'b0);
        foreach (directed_x[i]) send_item(ffc_pkg::OP_X2F, $urandom, directed_x[i]);
        drain();
        write_format(6'd0, 6'd0, 1'b1);
        send_item(ffc_pkg::OP_F2X, 32'h0000_0000, 32'd0);
        send_item(ffc_pkg::OP_F2X, 32'h3E80_0000, 32'd0);
        send_item(ffc_pkg::OP_X2F, 32'd0, 32'h0000_0000);
        send_item(ffc_pkg::OP_X2F, 32'd0, 32'h0000_0001);
        drain();
        write_format(6'd63, 6'd63, 1'b0);
        send_item(ffc_pkg::OP_F2X, 32'h3F80_0000, 32'd0);
        send_item(ffc_pkg::OP_X2F, 32'd0, 32'h1234_5678);
        drain();
        write_format(6'd32, 6'd0, 1'b0);
        random_items(40);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            if ($urandom_range(0, 5) == 0) begin
                fr = 6'($urandom_range(0, 63));
                ib = 6'($urandom_range(0, 63));
            end else begin
                fr = 6'($urandom_range(0, 32));
                ib = 6'($urandom_range(0, 32 - fr));
            end
            drain();
            write_format(fr, ib, 1'($urandom_range(0, 1)));
            if (phase == 11) calm = 1'b1;
            random_items(85);
        end
        drain();

        $display("Checked %0d conversions over %0d sent items, both directions, 18 formats.",
                 sb.checked, sent);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("float_fixed_converter_unit regression: pass");
        end else begin
            $display("float_fixed_converter_unit regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
